[hdl/fsp_pkg.sv]
// ============================================================================
// fsp_pkg: shared types and constants of the floppy track sector parser
// Byte codes of the track layout, register indexes, state codes and the
// structs that carry parser context, results and configuration.
// ============================================================================
package fsp_pkg;

    // byte codes of the track layout
    localparam logic [7:0] FILL_BYTE = 8'h4E;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE = 8'hA1;
    localparam logic [7:0] ID_MARK   = 8'hFE;

    // run lengths of the fixed parts of a sector
    localparam logic [10:0] SYNC_COUNT = 11'd3;
    localparam logic [10:0] CRC_COUNT  = 11'd2;
    localparam logic [7:0]  TALLY_MAX  = 8'd255;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP2_FILL_MIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP2_ZERO_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP3_FILL_MIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP3_ZERO_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_BYTES    = 3'd4;

    // configuration reset values
    localparam logic [7:0]  GAP2_FILL_MIN_RST   = 8'd15;
    localparam logic [7:0]  GAP2_ZERO_COUNT_RST = 8'd8;
    localparam logic [7:0]  GAP3_FILL_MIN_RST   = 8'd22;
    localparam logic [7:0]  GAP3_ZERO_COUNT_RST = 8'd8;
    localparam logic [10:0] SECTOR_BYTES_RST    = 11'd256;

    // parser states, one-hot
    typedef enum logic [15:0] {
        ST_HUNT   = 16'h0001,
        ST_G2FILL = 16'h0002,
        ST_G2ZERO = 16'h0004,
        ST_G2SYNC = 16'h0008,
        ST_IDMARK = 16'h0010,
        ST_TRACK  = 16'h0020,
        ST_SIDE   = 16'h0040,
        ST_SECTOR = 16'h0080,
        ST_LEN    = 16'h0100,
        ST_IDCRC  = 16'h0200,
        ST_G3FILL = 16'h0400,
        ST_G3ZERO = 16'h0800,
        ST_G3SYNC = 16'h1000,
        ST_DMARK  = 16'h2000,
        ST_DATA   = 16'h4000,
        ST_DCRC   = 16'h8000
    } fsp_state_t;

    // reported state codes
    localparam logic [3:0] CODE_HUNT   = 4'd0;
    localparam logic [3:0] CODE_G2FILL = 4'd1;
    localparam logic [3:0] CODE_G2ZERO = 4'd2;
    localparam logic [3:0] CODE_G2SYNC = 4'd3;
    localparam logic [3:0] CODE_IDMARK = 4'd4;
    localparam logic [3:0] CODE_TRACK  = 4'd5;
    localparam logic [3:0] CODE_SIDE   = 4'd6;
    localparam logic [3:0] CODE_SECTOR = 4'd7;
    localparam logic [3:0] CODE_LEN    = 4'd8;
    localparam logic [3:0] CODE_IDCRC  = 4'd9;
    localparam logic [3:0] CODE_G3FILL = 4'd10;
    localparam logic [3:0] CODE_G3ZERO = 4'd11;
    localparam logic [3:0] CODE_G3SYNC = 4'd12;
    localparam logic [3:0] CODE_DMARK  = 4'd13;
    localparam logic [3:0] CODE_DATA   = 4'd14;
    localparam logic [3:0] CODE_DCRC   = 4'd15;

    // parser context carried from word to word
    typedef struct packed {
        fsp_state_t  state;
        logic [10:0] run_count;
        logic [7:0]  held_track;
        logic [7:0]  held_side;
        logic [7:0]  held_sector;
        logic [7:0]  held_length;
        logic [7:0]  held_mark;
        logic [15:0] crc_shift;
        logic [7:0]  sector_tally;
    } fsp_ctx_t;

    // one result word
    typedef struct packed {
        logic [3:0] parse_state;
        logic       id_valid;
        logic [7:0] id_track;
        logic [7:0] id_side;
        logic [7:0] id_sector;
        logic [7:0] id_length_code;
        logic [7:0] data_mark;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       sector_done;
        logic [7:0] sectors_in_track;
    } fsp_result_t;

    // configuration registers
    typedef struct packed {
        logic [7:0]  gap2_fill_min;
        logic [7:0]  gap2_zero_count;
        logic [7:0]  gap3_fill_min;
        logic [7:0]  gap3_zero_count;
        logic [10:0] sector_bytes;
    } fsp_cfg_t;

endpackage

[hdl/fsp_cfg.sv]
// ============================================================================
// fsp_cfg: configuration registers of the floppy track sector parser
// Decodes the register index of each configuration write and holds the
// gap, zero-run and sector length settings.
// ============================================================================
module fsp_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [10:0]                    wr_data,
    output fsp_pkg::fsp_cfg_t              cfg
);

    import fsp_pkg::*;

    fsp_cfg_t cfg_reg;
    fsp_cfg_t cfg_next;

    // index decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_GAP2_FILL_MIN:   cfg_next.gap2_fill_min   = wr_data[7:0];
                REG_GAP2_ZERO_COUNT: cfg_next.gap2_zero_count = wr_data[7:0];
                REG_GAP3_FILL_MIN:   cfg_next.gap3_fill_min   = wr_data[7:0];
                REG_GAP3_ZERO_COUNT: cfg_next.gap3_zero_count = wr_data[7:0];
                REG_SECTOR_BYTES:    cfg_next.sector_bytes    = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap2_fill_min   <= GAP2_FILL_MIN_RST;
            cfg_reg.gap2_zero_count <= GAP2_ZERO_COUNT_RST;
            cfg_reg.gap3_fill_min   <= GAP3_FILL_MIN_RST;
            cfg_reg.gap3_zero_count <= GAP3_ZERO_COUNT_RST;
            cfg_reg.sector_bytes    <= SECTOR_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/fsp_step.sv]
// ============================================================================
// fsp_step: next-state logic of the floppy track sector parser
// Judges one track byte against the sector layout and gives the updated
// parser context together with the result word for that byte.
// ============================================================================
module fsp_step
(
    input  logic                 track_start,
    input  logic [7:0]           raw_byte,
    input  fsp_pkg::fsp_cfg_t    cfg,
    input  fsp_pkg::fsp_ctx_t    ctx_cur,
    output fsp_pkg::fsp_ctx_t    ctx_nxt,
    output fsp_pkg::fsp_result_t res
);

    import fsp_pkg::*;

    typedef struct packed {
        fsp_state_t  state;
        logic [10:0] count;
    } run_t;

    // fill run: count fill bytes up to the minimum, leave on a zero at the minimum
    function automatic run_t fill_step(
        input logic [7:0]  b,
        input logic [10:0] count,
        input logic [7:0]  minimum,
        input fsp_state_t  stay,
        input fsp_state_t  leave
    );
        run_t r;
        r.state = stay;
        r.count = count;
        if (b == FILL_BYTE)
        begin
            if (count < {3'b000, minimum})
            begin
                r.count = count + 11'd1;
            end
        end
        else if ((b == ZERO_BYTE) && (count == {3'b000, minimum}))
        begin
            r.count = 11'd1;
            r.state = leave;
        end
        else
        begin
            r.state = ST_HUNT;
        end
        return r;
    endfunction

    // zero run: count zeros up to the need, leave on a sync byte at the need
    function automatic run_t zero_step(
        input logic [7:0]  b,
        input logic [10:0] count,
        input logic [7:0]  need,
        input fsp_state_t  stay,
        input fsp_state_t  leave
    );
        run_t r;
        r.state = stay;
        r.count = count;
        if (b == ZERO_BYTE)
        begin
            if (count < {3'b000, need})
            begin
                r.count = count + 11'd1;
            end
        end
        else if ((b == SYNC_BYTE) && (count == {3'b000, need}))
        begin
            r.count = 11'd1;
            r.state = leave;
        end
        else
        begin
            r.state = ST_HUNT;
        end
        return r;
    endfunction

    // sync run: three sync bytes in a row
    function automatic run_t sync_step(
        input logic [7:0]  b,
        input logic [10:0] count,
        input fsp_state_t  stay,
        input fsp_state_t  leave
    );
        run_t r;
        r.state = stay;
        r.count = count + 11'd1;
        if (b != SYNC_BYTE)
        begin
            r.state = ST_HUNT;
            r.count = count;
        end
        else if (r.count == SYNC_COUNT)
        begin
            r.state = leave;
        end
        return r;
    endfunction

    // reported code of a state
    function automatic logic [3:0] state_code(input fsp_state_t s);
        logic [3:0] c;
        unique case (s)
            ST_G2FILL: c = CODE_G2FILL;
            ST_G2ZERO: c = CODE_G2ZERO;
            ST_G2SYNC: c = CODE_G2SYNC;
            ST_IDMARK: c = CODE_IDMARK;
            ST_TRACK:  c = CODE_TRACK;
            ST_SIDE:   c = CODE_SIDE;
            ST_SECTOR: c = CODE_SECTOR;
            ST_LEN:    c = CODE_LEN;
            ST_IDCRC:  c = CODE_IDCRC;
            ST_G3FILL: c = CODE_G3FILL;
            ST_G3ZERO: c = CODE_G3ZERO;
            ST_G3SYNC: c = CODE_G3SYNC;
            ST_DMARK:  c = CODE_DMARK;
            ST_DATA:   c = CODE_DATA;
            ST_DCRC:   c = CODE_DCRC;
            default:   c = CODE_HUNT;
        endcase
        return c;
    endfunction

    fsp_ctx_t    ctx;
    run_t        run;
    logic [10:0] cnt_inc;
    logic        id_done;
    logic        data_strobe;
    logic [7:0]  data_out;
    logic        sector_end;

    // parser transition for one byte
    always_comb
    begin
        ctx         = ctx_cur;
        run         = '{state: ST_HUNT, count: 11'd0};
        id_done     = 1'b0;
        data_strobe = 1'b0;
        data_out    = 8'h00;
        sector_end  = 1'b0;

        // track start restarts the hunt and the sector count
        if (track_start)
        begin
            ctx.state        = ST_HUNT;
            ctx.run_count    = 11'd0;
            ctx.sector_tally = 8'd0;
        end

        // a byte seen while hunting is the first byte of the gap fill
        if (ctx.state == ST_HUNT)
        begin
            ctx.run_count = 11'd0;
            ctx.state     = ST_G2FILL;
        end

        cnt_inc = ctx.run_count + 11'd1;

        unique case (ctx.state)
            ST_G2FILL:
            begin
                run = fill_step(raw_byte, ctx.run_count, cfg.gap2_fill_min,
                                ST_G2FILL, ST_G2ZERO);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_G2ZERO:
            begin
                run = zero_step(raw_byte, ctx.run_count, cfg.gap2_zero_count,
                                ST_G2ZERO, ST_G2SYNC);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_G2SYNC:
            begin
                run = sync_step(raw_byte, ctx.run_count, ST_G2SYNC, ST_IDMARK);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_IDMARK:
            begin
                ctx.state = (raw_byte == ID_MARK) ? ST_TRACK : ST_HUNT;
            end
            ST_TRACK:
            begin
                ctx.held_track = raw_byte;
                ctx.state      = ST_SIDE;
            end
            ST_SIDE:
            begin
                ctx.held_side = raw_byte;
                ctx.state     = ST_SECTOR;
            end
            ST_SECTOR:
            begin
                ctx.held_sector = raw_byte;
                ctx.state       = ST_LEN;
            end
            ST_LEN:
            begin
                ctx.held_length = raw_byte;
                ctx.run_count   = 11'd0;
                ctx.state       = ST_IDCRC;
            end
            ST_IDCRC:
            begin
                ctx.crc_shift = {ctx.crc_shift[7:0], raw_byte};
                ctx.run_count = cnt_inc;
                if (cnt_inc == CRC_COUNT)
                begin
                    id_done       = 1'b1;
                    ctx.run_count = 11'd0;
                    ctx.state     = ST_G3FILL;
                end
            end
            ST_G3FILL:
            begin
                run = fill_step(raw_byte, ctx.run_count, cfg.gap3_fill_min,
                                ST_G3FILL, ST_G3ZERO);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_G3ZERO:
            begin
                run = zero_step(raw_byte, ctx.run_count, cfg.gap3_zero_count,
                                ST_G3ZERO, ST_G3SYNC);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_G3SYNC:
            begin
                run = sync_step(raw_byte, ctx.run_count, ST_G3SYNC, ST_DMARK);
                ctx.state     = run.state;
                ctx.run_count = run.count;
            end
            ST_DMARK:
            begin
                ctx.held_mark = raw_byte;
                ctx.run_count = 11'd0;
                ctx.state     = ST_DATA;
            end
            ST_DATA:
            begin
                data_strobe   = 1'b1;
                data_out      = raw_byte;
                ctx.run_count = cnt_inc;
                // a wrapped count ends the field as well
                if ((cnt_inc >= cfg.sector_bytes) || (cnt_inc == 11'd0))
                begin
                    ctx.run_count = 11'd0;
                    ctx.state     = ST_DCRC;
                end
            end
            ST_DCRC:
            begin
                ctx.crc_shift = {ctx.crc_shift[7:0], raw_byte};
                ctx.run_count = cnt_inc;
                if (cnt_inc == CRC_COUNT)
                begin
                    sector_end = 1'b1;
                    if (ctx.sector_tally < TALLY_MAX)
                    begin
                        ctx.sector_tally = ctx.sector_tally + 8'd1;
                    end
                    ctx.state = ST_HUNT;
                end
            end
            default:
            begin
                ctx.state = ST_HUNT;
            end
        endcase
    end

    // result word for this byte
    assign ctx_nxt                  = ctx;
    assign res.parse_state          = state_code(ctx.state);
    assign res.id_valid             = id_done;
    assign res.id_track             = ctx.held_track;
    assign res.id_side              = ctx.held_side;
    assign res.id_sector            = ctx.held_sector;
    assign res.id_length_code       = ctx.held_length;
    assign res.data_mark            = ctx.held_mark;
    assign res.data_valid           = data_strobe;
    assign res.data_byte            = data_out;
    assign res.sector_done          = sector_end;
    assign res.sectors_in_track     = ctx.sector_tally;

endmodule

[hdl/floppy_track_sector_parser.sv]
// ============================================================================
// floppy_track_sector_parser: MFM floppy track layout parser
// Walks the gap, sync, ID field and data field of each sector of a decoded
// track, one byte per word, and reports ID fields, data strobes and counts.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries raw_byte and track_start, one
//   track byte per word; track_start restarts the hunt and the sector count
//   before that byte is judged.
//   Output channel (out_valid/out_ready) returns exactly one result word per
//   input word, in order: parse_state, the held ID fields and data mark,
//   data_valid/data_byte strobes, sector_done and sectors_in_track.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the gap, zero-run and sector length registers; cfg_ready is always high
//   and writes beyond the register list are dropped. Write only when idle.
//   The path runs from the input register through one pass of the parser
//   logic to the result register, from which the result word is taken.
//   Throughput: one word per cycle, sustained while the receiver keeps
//   out_ready high.
//   When the receiver stalls, the result register holds and the input
//   register takes one more word; in_ready then drops until the result moves.
//   Reset clears the parser context, the sector count and both handshakes,
//   and loads the register defaults; no clearing pass is needed.
// ============================================================================
module floppy_track_sector_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      raw_byte,
    input  logic                            track_start,
    // result words
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [3:0]                      parse_state,
    output logic                            id_valid,
    output logic [7:0]                      id_track,
    output logic [7:0]                      id_side,
    output logic [7:0]                      id_sector,
    output logic [7:0]                      id_length_code,
    output logic [7:0]                      data_mark,
    output logic                            data_valid,
    output logic [7:0]                      data_byte,
    output logic                            sector_done,
    output logic [7:0]                      sectors_in_track,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [10:0]                     cfg_data
);

    import fsp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    fsp_result_t res_reg;
    fsp_ctx_t    ctx_reg;

    fsp_cfg_t    cfg;
    fsp_ctx_t    ctx_next;
    fsp_result_t res_next;
    logic        advance;
    logic        in_take;

    // configuration registers
    assign cfg_ready = 1'b1;

    fsp_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // parser logic between input and result registers
    fsp_step u_step
    (
        .track_start (in_start_reg),
        .raw_byte    (in_byte_reg),
        .cfg         (cfg),
        .ctx_cur     (ctx_reg),
        .ctx_nxt     (ctx_next),
        .res         (res_next)
    );

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= raw_byte;
            in_start_reg <= track_start;
        end
    end

    // parser context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state        <= ST_HUNT;
            ctx_reg.run_count    <= 11'd0;
            ctx_reg.held_track   <= 8'd0;
            ctx_reg.held_side    <= 8'd0;
            ctx_reg.held_sector  <= 8'd0;
            ctx_reg.held_length  <= 8'd0;
            ctx_reg.held_mark    <= 8'd0;
            ctx_reg.crc_shift    <= 16'd0;
            ctx_reg.sector_tally <= 8'd0;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign parse_state      = res_reg.parse_state;
    assign id_valid         = res_reg.id_valid;
    assign id_track         = res_reg.id_track;
    assign id_side          = res_reg.id_side;
    assign id_sector        = res_reg.id_sector;
    assign id_length_code   = res_reg.id_length_code;
    assign data_mark        = res_reg.data_mark;
    assign data_valid       = res_reg.data_valid;
    assign data_byte        = res_reg.data_byte;
    assign sector_done      = res_reg.sector_done;
    assign sectors_in_track = res_reg.sectors_in_track;

endmodule

[tb/floppy_parse_checker.sv]
// ============================================================================
// floppy_parse_checker: result checker for the floppy track sector parser
// Watches the byte, result and register channels of the parser. Each byte
// that is taken runs through a local model of the track layout walk, and
// each result word that leaves the block is compared field by field with
// the oldest predicted word.
// ============================================================================
module floppy_parse_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    // byte channel
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      raw_byte,
    input  logic                            track_start,
    // result channel
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [3:0]                      parse_state,
    input  logic                            id_valid,
    input  logic [7:0]                      id_track,
    input  logic [7:0]                      id_side,
    input  logic [7:0]                      id_sector,
    input  logic [7:0]                      id_length_code,
    input  logic [7:0]                      data_mark,
    input  logic                            data_valid,
    input  logic [7:0]                      data_byte,
    input  logic                            sector_done,
    input  logic [7:0]                      sectors_in_track,
    // register channel
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [10:0]                     cfg_data,
    // status to the testbench top
    output int                              mismatch_count,
    output int                              results_in_flight
);

    import fsp_pkg::*;

    // local copy of the layout registers
    logic [7:0]  fill2_min;
    logic [7:0]  zeros2_need;
    logic [7:0]  fill3_min;
    logic [7:0]  zeros3_need;
    logic [10:0] user_len;

    // local copy of the parser context
    logic [3:0]  walk_state;
    logic [10:0] run_len;
    logic [7:0]  last_track;
    logic [7:0]  last_side;
    logic [7:0]  last_sector;
    logic [7:0]  last_len_code;
    logic [7:0]  last_mark;
    logic [7:0]  done_tally;

    // predicted result words, oldest first
    fsp_result_t track_results[$];

    int fails = 0;
    int owed  = 0;

    assign mismatch_count    = fails;
    assign results_in_flight = owed;

    // fill run: 0x4E counts up to the minimum, a zero moves on only there
    function automatic void fill_step(logic [7:0] b, logic [7:0] minimum, logic [3:0] next);
        if (b == FILL_BYTE)
        begin
            if (run_len < {3'b000, minimum})
                run_len = run_len + 11'd1;
        end
        else if (b == ZERO_BYTE && run_len == {3'b000, minimum})
        begin
            run_len    = 11'd1;
            walk_state = next;
        end
        else
            walk_state = CODE_HUNT;
    endfunction

    // zero run: 0x00 counts up to the need, a sync moves on only there
    function automatic void zero_step(logic [7:0] b, logic [7:0] need, logic [3:0] next);
        if (b == ZERO_BYTE)
        begin
            if (run_len < {3'b000, need})
                run_len = run_len + 11'd1;
        end
        else if (b == SYNC_BYTE && run_len == {3'b000, need})
        begin
            run_len    = 11'd1;
            walk_state = next;
        end
        else
            walk_state = CODE_HUNT;
    endfunction

    // sync run: third 0xA1 in a row moves on
    function automatic void sync_step(logic [7:0] b, logic [3:0] next);
        if (b == SYNC_BYTE)
        begin
            run_len = run_len + 11'd1;
            if (run_len == SYNC_COUNT)
                walk_state = next;
        end
        else
            walk_state = CODE_HUNT;
    endfunction

    // one track byte through the layout walk, giving its result word
    function automatic fsp_result_t parse_track_byte(logic [7:0] b, logic restart);
        fsp_result_t r;
        r = '0;
        if (restart)
        begin
            walk_state = CODE_HUNT;
            run_len    = '0;
            done_tally = '0;
        end
        // a byte taken while hunting is judged as the first fill byte
        if (walk_state == CODE_HUNT)
        begin
            run_len    = '0;
            walk_state = CODE_G2FILL;
        end
        case (walk_state)
            CODE_G2FILL: fill_step(b, fill2_min, CODE_G2ZERO);
            CODE_G2ZERO: zero_step(b, zeros2_need, CODE_G2SYNC);
            CODE_G2SYNC: sync_step(b, CODE_IDMARK);
            CODE_IDMARK: walk_state = (b == ID_MARK) ? CODE_TRACK : CODE_HUNT;
            CODE_TRACK:
            begin
                last_track = b;
                walk_state = CODE_SIDE;
            end
            CODE_SIDE:
            begin
                last_side  = b;
                walk_state = CODE_SECTOR;
            end
            CODE_SECTOR:
            begin
                last_sector = b;
                walk_state  = CODE_LEN;
            end
            CODE_LEN:
            begin
                last_len_code = b;
                run_len       = '0;
                walk_state    = CODE_IDCRC;
            end
            CODE_IDCRC:
            begin
                run_len = run_len + 11'd1;
                if (run_len == CRC_COUNT)
                begin
                    r.id_valid = 1'b1;
                    run_len    = '0;
                    walk_state = CODE_G3FILL;
                end
            end
            CODE_G3FILL: fill_step(b, fill3_min, CODE_G3ZERO);
            CODE_G3ZERO: zero_step(b, zeros3_need, CODE_G3SYNC);
            CODE_G3SYNC: sync_step(b, CODE_DMARK);
            CODE_DMARK:
            begin
                last_mark  = b;
                run_len    = '0;
                walk_state = CODE_DATA;
            end
            CODE_DATA:
            begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
                run_len      = run_len + 11'd1;
                // a length of zero behaves like one
                if (run_len >= user_len || run_len == 11'd0)
                begin
                    run_len    = '0;
                    walk_state = CODE_DCRC;
                end
            end
            CODE_DCRC:
            begin
                run_len = run_len + 11'd1;
                if (run_len == CRC_COUNT)
                begin
                    r.sector_done = 1'b1;
                    if (done_tally < TALLY_MAX)
                        done_tally = done_tally + 8'd1;
                    walk_state = CODE_HUNT;
                end
            end
            default: walk_state = CODE_HUNT;
        endcase
        r.parse_state      = walk_state;
        r.id_track         = last_track;
        r.id_side          = last_side;
        r.id_sector        = last_sector;
        r.id_length_code   = last_len_code;
        r.data_mark        = last_mark;
        r.sectors_in_track = done_tally;
        return r;
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fails++;
        end
    endfunction

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        fsp_result_t want;
        if (!rst_n)
        begin
            fill2_min     = GAP2_FILL_MIN_RST;
            zeros2_need   = GAP2_ZERO_COUNT_RST;
            fill3_min     = GAP3_FILL_MIN_RST;
            zeros3_need   = GAP3_ZERO_COUNT_RST;
            user_len      = SECTOR_BYTES_RST;
            walk_state    = CODE_HUNT;
            run_len       = '0;
            last_track    = '0;
            last_side     = '0;
            last_sector   = '0;
            last_len_code = '0;
            last_mark     = '0;
            done_tally    = '0;
            track_results.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAP2_FILL_MIN:   fill2_min   = cfg_data[7:0];
                    REG_GAP2_ZERO_COUNT: zeros2_need = cfg_data[7:0];
                    REG_GAP3_FILL_MIN:   fill3_min   = cfg_data[7:0];
                    REG_GAP3_ZERO_COUNT: zeros3_need = cfg_data[7:0];
                    REG_SECTOR_BYTES:    user_len    = cfg_data;
                    default: ;
                endcase
            end
            // byte taken: predict its word
            if (in_valid && in_ready)
                track_results.push_back(parse_track_byte(raw_byte, track_start));
            // word delivered: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (track_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual state %0h",
                             $time, parse_state);
                    fails++;
                end
                else
                begin
                    want = track_results.pop_front();
                    check_field("parse_state", want.parse_state, parse_state);
                    check_field("id_valid", want.id_valid, id_valid);
                    check_field("id_track", want.id_track, id_track);
                    check_field("id_side", want.id_side, id_side);
                    check_field("id_sector", want.id_sector, id_sector);
                    check_field("id_length_code", want.id_length_code, id_length_code);
                    check_field("data_mark", want.data_mark, data_mark);
                    check_field("data_valid", want.data_valid, data_valid);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("sector_done", want.sector_done, sector_done);
                    check_field("sectors_in_track", want.sectors_in_track, sectors_in_track);
                end
            end
        end
        owed = track_results.size();
    end

endmodule

[tb/floppy_track_sector_parser_tb.sv]
// ============================================================================
// floppy_track_sector_parser_tb: testbench top of the floppy track parser
// Feeds directed and random track bytes (well-formed sectors, damaged
// sectors, noise and track restarts) under several layout settings, with
// random idling on both channels; the checker beside the block predicts
// and compares every result word, and this top gives the verdict.
// ============================================================================
module floppy_track_sector_parser_tb;
    import fsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [7:0]             raw_byte    = '0;
    logic                   track_start = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [3:0]             parse_state;
    logic                   id_valid;
    logic [7:0]             id_track;
    logic [7:0]             id_side;
    logic [7:0]             id_sector;
    logic [7:0]             id_length_code;
    logic [7:0]             data_mark;
    logic                   data_valid;
    logic [7:0]             data_byte;
    logic                   sector_done;
    logic [7:0]             sectors_in_track;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [10:0]            cfg_data    = '0;

    int          mismatch_count;
    int          results_in_flight;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    bit          quiet       = 1'b0;

    // layout currently loaded in the block
    int unsigned lay_fill2;
    int unsigned lay_zero2;
    int unsigned lay_fill3;
    int unsigned lay_zero3;
    int unsigned lay_len;

    floppy_track_sector_parser DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .raw_byte         (raw_byte),
        .track_start      (track_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .parse_state      (parse_state),
        .id_valid         (id_valid),
        .id_track         (id_track),
        .id_side          (id_side),
        .id_sector        (id_sector),
        .id_length_code   (id_length_code),
        .data_mark        (data_mark),
        .data_valid       (data_valid),
        .data_byte        (data_byte),
        .sector_done      (sector_done),
        .sectors_in_track (sectors_in_track),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    floppy_parse_checker parse_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_byte          (raw_byte),
        .track_start       (track_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .parse_state       (parse_state),
        .id_valid          (id_valid),
        .id_track          (id_track),
        .id_side           (id_side),
        .id_sector         (id_sector),
        .id_length_code    (id_length_code),
        .data_mark         (data_mark),
        .data_valid        (data_valid),
        .data_byte         (data_byte),
        .sector_done       (sector_done),
        .sectors_in_track  (sectors_in_track),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .results_in_flight (results_in_flight)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("floppy_track_sector_parser test failed");
            $finish;
        end
    end

    // receiver pacing: ready stretches and stall bursts
    initial
    begin : sink_pacing
        int span;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_ready = 1'b1;
                span = $urandom_range(1, 30);
            end
            else
            begin
                out_ready = 1'b0;
                span = $urandom_range(1, 18);
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    // one track byte; called and returns at a falling edge
    task automatic put_byte(input logic [7:0] b, input logic restart);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid    = 1'b1;
        raw_byte    = b;
        track_start = restart;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
        bytes_sent++;
    endtask

    // hold off until every predicted word has come back
    task automatic settle();
        while (results_in_flight != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[10:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // load a full layout; only while the block is idle
    task automatic set_layout(input int unsigned f2, input int unsigned z2,
                              input int unsigned f3, input int unsigned z3,
                              input int unsigned len);
        settle();
        write_reg(REG_GAP2_FILL_MIN, f2);
        write_reg(REG_GAP2_ZERO_COUNT, z2);
        write_reg(REG_GAP3_FILL_MIN, f3);
        write_reg(REG_GAP3_ZERO_COUNT, z3);
        write_reg(REG_SECTOR_BYTES, len);
        lay_fill2 = f2;
        lay_zero2 = z2;
        lay_fill3 = f3;
        lay_zero3 = z3;
        lay_len   = len;
    endtask

    // bytes that often land near the layout codes
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 4))
            0: return FILL_BYTE;
            1: return ZERO_BYTE;
            2: return SYNC_BYTE;
            3: return ID_MARK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // fill run, zero run and sync bytes ahead of a field
    task automatic add_gap(ref logic [7:0] seq[$], input int unsigned fill,
                           input int unsigned need);
        repeat (fill + $urandom_range(0, 2)) seq.push_back(FILL_BYTE);
        repeat (((need == 0) ? 1 : need) + $urandom_range(0, 1)) seq.push_back(ZERO_BYTE);
        repeat (3) seq.push_back(SYNC_BYTE);
    endtask

    // one sector in the current layout, optionally damaged
    task automatic send_sector(input bit damage, input bit restart);
        logic [7:0] seq[$];
        int unsigned pos;
        add_gap(seq, lay_fill2, lay_zero2);
        seq.push_back(ID_MARK);
        // track, side, sector, length code and the two ID crc bytes
        repeat (6) seq.push_back(8'($urandom_range(0, 255)));
        add_gap(seq, lay_fill3, lay_zero3);
        // data mark, user bytes and the two data crc bytes
        repeat (((lay_len == 0) ? 1 : lay_len) + 3)
            seq.push_back(8'($urandom_range(0, 255)));
        if (damage)
        begin
            pos = $urandom_range(0, seq.size() - 1);
            case ($urandom_range(0, 2))
                0: seq[pos] = 8'($urandom_range(0, 255));
                1: while (seq.size() > pos + 1) seq.pop_back();
                default: seq.insert(pos, noise_byte());
            endcase
        end
        foreach (seq[i])
            put_byte(seq[i], restart && i == 0);
    endtask

    // mostly clean sectors, with damage, noise, restarts and drain pauses
    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            case ($urandom_range(0, 11))
                7, 8: repeat ($urandom_range(1, 8)) put_byte(noise_byte(), 1'b0);
                9: put_byte(noise_byte(), 1'b1);
                10: settle();
                default: send_sector($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            endcase
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [7:0] opening [24];
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: one sector with extreme field values, then two misfits
        set_layout(1, 1, 1, 1, 2);
        opening = '{FILL_BYTE, ZERO_BYTE, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, ID_MARK,
                    8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                    FILL_BYTE, ZERO_BYTE, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 8'hFB,
                    8'hFF, 8'h00, 8'h00, 8'hFF, ZERO_BYTE, 8'hFF};
        foreach (opening[i])
            put_byte(opening[i], i == 0);

        // zero fill minimum and zero sector length, then zero-count runs
        set_layout(0, 2, 0, 1, 0);
        repeat (3) send_sector(1'b0, 1'b0);
        set_layout(1, 0, 1, 1, 2);
        repeat (2) send_sector(1'b0, 1'b0);
        set_layout(1, 1, 2, 0, 2);
        repeat (2) send_sector(1'b0, 1'b0);

        // random small layouts
        repeat (3)
        begin
            set_layout($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 5),
                       $urandom_range(1, 4), $urandom_range(1, 12));
            random_traffic(70);
        end

        // last part without idling: clean sectors back to back
        quiet = 1'b1;
        set_layout(1, 1, 1, 1, 1);
        for (int k = 0; k < 3; k++)
            send_sector(1'b0, k == 0);
        put_byte(FILL_BYTE, 1'b1);

        settle();
        if (mismatch_count == 0)
            $display("floppy_track_sector_parser test passed");
        else
            $display("floppy_track_sector_parser test failed");
        $finish;
    end

endmodule

[sim.f]
hdl/fsp_pkg.sv
hdl/fsp_cfg.sv
hdl/fsp_step.sv
hdl/floppy_track_sector_parser.sv
tb/floppy_parse_checker.sv
tb/floppy_track_sector_parser_tb.sv
